FILE: rtl/fpp_pkg.sv
package fpp_pkg;

    localparam int NUM_CPUS = 8;
    localparam int CPU_W    = $clog2(NUM_CPUS);
    localparam int CNT_W    = 16;
    localparam int PRIO_W   = 7;
    localparam int PRI_W    = 8;

    localparam logic [CNT_W-1:0]  COUNT_MAX   = '1;
    localparam logic [PRIO_W-1:0] PRIO_HI     = 7'd99;
    localparam logic [PRIO_W-1:0] PRIO_LO     = 7'd1;

    // window*(p-1) stays below 25000, so floor(x/98) == (x*21400) >> 21
    localparam int PROD_W  = PRI_W + PRIO_W;
    localparam int SCALE_W = 2 * PROD_W;
    localparam int RECIP_SHIFT = 21;
    localparam logic [PROD_W-1:0] RECIP = 15'd21400;

    typedef enum logic [1:0] {
        CMD_ADMIT   = 2'd0,
        CMD_PLACE   = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_PARTIAL   = 2'd1,
        ST_NOCPU     = 2'd2,
        ST_UNDERFLOW = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_PRIO_TOP  = 2'd0,
        CFG_PRIO_BASE = 2'd1,
        CFG_CPU_MASK  = 2'd2,
        CFG_SPARE     = 2'd3
    } cfg_idx_t;

    // work the back end has to do for one word
    typedef enum logic [1:0] {
        OP_REPORT  = 2'd0,
        OP_PLACE   = 2'd1,
        OP_RELEASE = 2'd2
    } op_t;

    typedef struct packed {
        op_t               op;
        status_t           status;
        logic [PRIO_W-1:0] pm1;
        logic [CPU_W-1:0]  tcpu;
    } item_t;

    typedef struct packed {
        logic [PRI_W-1:0] prio_top;
        logic [PRI_W-1:0] prio_base;
        logic [7:0]       cpu_mask;
    } cfg_t;

endpackage

FILE: rtl/fpp_front.sv
module fpp_front (
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   cmd,
    input  logic [fpp_pkg::PRIO_W-1:0]   priority_req,
    input  logic                         skip_admission,
    input  logic                         prefers_other,
    input  logic [fpp_pkg::CPU_W-1:0]    task_cpu,
    input  logic                         q_full,
    output logic                         push,
    output fpp_pkg::item_t               item
);
    import fpp_pkg::*;

    logic [PRIO_W-1:0] prio_clamped;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    assign prio_clamped = (priority_req > PRIO_HI) ? PRIO_HI : priority_req;

    always_comb
    begin
        item.op     = OP_REPORT;
        item.status = ST_OK;
        item.tcpu   = task_cpu;
        // priority 0 maps to the window's lower end, same as p-1 == 0
        item.pm1    = (prio_clamped == '0) ? '0 : prio_clamped - PRIO_LO;
        unique case (cmd_t'(cmd))
            CMD_ADMIT:
            begin
                if ((!skip_admission && priority_req == '0) || prefers_other)
                    item.status = ST_PARTIAL;
            end
            CMD_PLACE:
                item.op = OP_PLACE;
            CMD_RELEASE:
            begin
                if (int'(task_cpu) < NUM_CPUS)
                    item.op = OP_RELEASE;
            end
            CMD_NOP:
                item.op = OP_REPORT;
            default:
                item.op = OP_REPORT;
        endcase
    end

endmodule

FILE: rtl/fpp_queue.sv
module fpp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fpp_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output fpp_pkg::item_t pop_item,
    output logic           empty
);
    import fpp_pkg::*;

    localparam int DEPTH = 2;

    item_t       mem_reg [DEPTH];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full     = (count_reg == 2'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && !empty))
            count_next = count_reg + 2'd1;
        else if (!push && pop && !empty)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop && !empty)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/fpp_back.sv
module fpp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fpp_pkg::cfg_t               cfg,
    input  logic                        q_empty,
    input  fpp_pkg::item_t              q_item,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [fpp_pkg::CPU_W-1:0]   chosen_cpu,
    output logic [fpp_pkg::PRI_W-1:0]   real_priority
);
    import fpp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_MUL  = 6'b000100,
        S_DIV  = 6'b001000,
        S_REL  = 6'b010000,
        S_FIN  = 6'b100000
    } state_t;

    localparam logic [CPU_W-1:0] LAST_CPU = CPU_W'(NUM_CPUS - 1);

    state_t             state_reg, state_next;
    item_t              item_reg;
    logic [CNT_W-1:0]   cnt_reg [NUM_CPUS];
    logic [CPU_W-1:0]   scan_idx_reg;
    logic               found_reg;
    logic [CPU_W-1:0]   best_reg;
    logic [CNT_W-1:0]   best_cnt_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [SCALE_W-1:0] scaled_reg;
    status_t            pend_status_reg;
    logic [CPU_W-1:0]   pend_cpu_reg;
    logic               pend_place_reg;
    logic               out_valid_reg;
    status_t            status_reg;
    logic [CPU_W-1:0]   chosen_reg;
    logic [PRI_W-1:0]   real_reg;

    logic [CPU_W-1:0]   rd_idx;
    logic [CNT_W-1:0]   rd_cnt;
    logic [PRI_W-1:0]   window;
    logic               take;
    logic               out_load;

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign chosen_cpu    = chosen_reg;
    assign real_priority = real_reg;

    assign pop      = (state_reg == S_IDLE) && !q_empty;
    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    // one read port onto the counters, steered by the state
    always_comb
    begin
        unique case (state_reg)
            S_REL:   rd_idx = item_reg.tcpu;
            S_MUL:   rd_idx = best_reg;
            default: rd_idx = scan_idx_reg;
        endcase
    end
    assign rd_cnt = cnt_reg[rd_idx];

    assign window = (cfg.prio_top >= cfg.prio_base) ? cfg.prio_top - cfg.prio_base : '0;
    assign take   = cfg.cpu_mask[scan_idx_reg] && (!found_reg || rd_cnt < best_cnt_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    unique case (q_item.op)
                        OP_PLACE:   state_next = S_SCAN;
                        OP_RELEASE: state_next = S_REL;
                        default:    state_next = S_FIN;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_idx_reg == LAST_CPU)
                    state_next = (found_reg || take) ? S_MUL : S_FIN;
            end
            S_MUL:   state_next = S_DIV;
            S_DIV:   state_next = S_FIN;
            S_REL:   state_next = S_FIN;
            S_FIN:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CPUS; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_MUL && rd_cnt != COUNT_MAX)
                cnt_reg[best_reg] <= rd_cnt + 1'b1;
            if (state_reg == S_REL && rd_cnt != '0)
                cnt_reg[item_reg.tcpu] <= rd_cnt - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                item_reg        <= q_item;
                scan_idx_reg    <= '0;
                found_reg       <= 1'b0;
                best_reg        <= '0;
                best_cnt_reg    <= '0;
                pend_status_reg <= q_item.status;
                pend_cpu_reg    <= '0;
                pend_place_reg  <= 1'b0;
            end
            S_SCAN:
            begin
                if (take)
                begin
                    found_reg    <= 1'b1;
                    best_reg     <= scan_idx_reg;
                    best_cnt_reg <= rd_cnt;
                end
                scan_idx_reg <= scan_idx_reg + 1'b1;
                if (scan_idx_reg == LAST_CPU && !(found_reg || take))
                    pend_status_reg <= ST_NOCPU;
            end
            S_MUL:
            begin
                prod_reg        <= PROD_W'(window) * PROD_W'(item_reg.pm1);
                pend_status_reg <= ST_OK;
                pend_cpu_reg    <= best_reg;
                pend_place_reg  <= 1'b1;
            end
            S_DIV:
                scaled_reg <= SCALE_W'(prod_reg) * SCALE_W'(RECIP);
            S_REL:
                pend_status_reg <= (rd_cnt == '0) ? ST_UNDERFLOW : ST_OK;
            S_FIN:
            begin
                if (out_load)
                begin
                    status_reg <= pend_status_reg;
                    chosen_reg <= pend_cpu_reg;
                    real_reg   <= pend_place_reg
                                ? cfg.prio_base + scaled_reg[RECIP_SHIFT +: PRI_W] : '0;
                end
            end
            default:
                scan_idx_reg <= '0;
        endcase
    end

endmodule

FILE: rtl/fixed_priority_task_placer_top.sv
// Least-loaded task placer for eight CPUs. Each word on the input side is an
// admit, place, release or unused command and gives exactly one result word.
// Words queue in a two-deep buffer and are carried out one at a time: a place
// scans the per-CPU task counters through a single comparator, one CPU a
// cycle, then does the count update with the window multiply, then the
// reciprocal multiply that divides by 98, then the result load (straight to
// the load when no CPU is enabled); a release decrements the task's counter
// before the result load, and admit and the unused command go straight to
// it. The configuration port is always ready and is to be written only while
// no word is in flight. Counters reset to zero and saturate at 0xFFFF.
module fixed_priority_task_placer_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   cmd,
    input  logic [fpp_pkg::PRIO_W-1:0]   priority_req,
    input  logic                         skip_admission,
    input  logic                         prefers_other,
    input  logic [fpp_pkg::CPU_W-1:0]    task_cpu,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [7:0]                   cfg_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [fpp_pkg::CPU_W-1:0]    chosen_cpu,
    output logic [fpp_pkg::PRI_W-1:0]    real_priority
);
    import fpp_pkg::*;

    cfg_t  cfg_reg;
    item_t push_item;
    item_t pop_item;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prio_top  <= 8'd99;
            cfg_reg.prio_base <= 8'd1;
            cfg_reg.cpu_mask  <= 8'hFF;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PRIO_TOP:  cfg_reg.prio_top  <= cfg_data;
                CFG_PRIO_BASE: cfg_reg.prio_base <= cfg_data;
                CFG_CPU_MASK:  cfg_reg.cpu_mask  <= cfg_data;
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    fpp_front u_front (
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .priority_req   (priority_req),
        .skip_admission (skip_admission),
        .prefers_other  (prefers_other),
        .task_cpu       (task_cpu),
        .q_full         (q_full),
        .push           (push),
        .item           (push_item)
    );

    fpp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    fpp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_empty       (q_empty),
        .q_item        (pop_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .chosen_cpu    (chosen_cpu),
        .real_priority (real_priority)
    );

endmodule
